@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the brightness core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define DBSB_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond holds in every cycle
`define DBSB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

@@ hw/rtl/dbsb_pkg.sv @@
// ----------------------------------------------------------------------------
// dbsb_pkg
// Types and fixed-point constants of the disk plus bulge brightness core.
// ----------------------------------------------------------------------------
package dbsb_pkg;

  // Configuration port
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_XX      = 3'd0,
    REG_SHAPE_YY      = 3'd1,
    REG_SHAPE_XY      = 3'd2,
    REG_DISK_NORM     = 3'd3,
    REG_BULGE_NORM    = 3'd4,
    REG_BULGE_INV_RSQ = 3'd5,
    REG_BULGE_ENABLE  = 3'd6
  } cfg_reg_t;

  // log2(e) in Q32, ln(2) in Q32, 7.6693*log2(e) in Q24
  localparam logic [32:0] LOG2E_Q32   = 33'd6196328019;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [27:0] BULGE_K_Q24 = 28'd185630853;

  // Result is dropped below 1/CUTOFF_SCALE of the active norms
  localparam logic [13:0] CUTOFF_SCALE = 14'd10000;

  // Base-2 exponent in Q32 and exponential result in Q32 (at most 1.0)
  localparam int          EXPO_W    = 38;
  localparam int          ONE_W     = 33;
  localparam logic [32:0] EXP_ONE   = 33'h1_0000_0000;
  localparam int          NUM_TERMS = 38;

  // Special-case flags that travel down the pipeline with each transaction
  typedef struct packed {
    logic disk_neg;
    logic disk_far;
    logic bulge_far;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

endpackage

@@ hw/rtl/dbsb_isqrt.sv @@
// ----------------------------------------------------------------------------
// dbsb_isqrt
// Pipelined floor square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module dbsb_isqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  logic [SIDE_W-1:0] side [ROOT_W];
  logic              vld  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [RAD_W-1:0]  p_rad;
    logic [SIDE_W-1:0] p_side;
    logic              p_v;
    logic [REM_W-1:0]  acc;
    logic [REM_W-1:0]  trial;

    // Take the previous stage, or the inputs at the head
    if (i == 0) begin : g_head
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
      assign p_v    = in_valid;
    end else begin : g_body
      assign p_rem  = rem[i-1];
      assign p_root = root[i-1];
      assign p_rad  = rad[i-1];
      assign p_side = side[i-1];
      assign p_v    = vld[i-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign acc   = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= p_v;
      end
      if (adv) begin
        if (acc >= trial) begin
          rem[i]  <= acc - trial;
          root[i] <= {p_root[ROOT_W-2:0], 1'b1};
        end else begin
          rem[i]  <= acc;
          root[i] <= {p_root[ROOT_W-2:0], 1'b0};
        end
        rad[i]  <= p_rad << 2;
        side[i] <= p_side;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

@@ hw/rtl/dbsb_exp2.sv @@
// ----------------------------------------------------------------------------
// dbsb_exp2
// Pipelined 2^-w in Q32: alternating series of exp(-f*ln2), then shift by k.
// ----------------------------------------------------------------------------
module dbsb_exp2 #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [dbsb_pkg::EXPO_W-1:0]     in_expo,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [dbsb_pkg::ONE_W-1:0]      out_val,
  output logic [SIDE_W-1:0]               out_side
);

  import dbsb_pkg::*;

  localparam int K_W = EXPO_W - 32;

  // Series state after each term: pending term, partial sum, ratio, shift
  logic [31:0]       c_t    [NUM_TERMS+1];
  logic [ONE_W-1:0]  c_s    [NUM_TERMS+1];
  logic [31:0]       c_g    [NUM_TERMS+1];
  logic [K_W-1:0]    c_k    [NUM_TERMS+1];
  logic [SIDE_W-1:0] c_side [NUM_TERMS+1];
  logic              c_v    [NUM_TERMS+1];

  // Product stage in front of each divide
  logic [63:0]       b_m    [NUM_TERMS+1];
  logic [ONE_W-1:0]  b_s    [NUM_TERMS+1];
  logic [31:0]       b_g    [NUM_TERMS+1];
  logic [K_W-1:0]    b_k    [NUM_TERMS+1];
  logic [SIDE_W-1:0] b_side [NUM_TERMS+1];
  logic              b_v    [NUM_TERMS+1];

  logic [63:0]      a_prod;
  logic [ONE_W-1:0] f_s;

  // Ratio g = f*ln2; first term is g itself
  assign a_prod = 64'(in_expo[31:0]) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= in_valid;
    end
    if (adv) begin
      c_g[0]    <= a_prod[63:32];
      c_t[0]    <= a_prod[63:32];
      c_s[0]    <= EXP_ONE;
      c_k[0]    <= in_expo[EXPO_W-1:32];
      c_side[0] <= in_side;
    end
  end

  for (genvar j = 1; j <= NUM_TERMS; j++) begin : g_term
    localparam int              TN    = j + 1;
    localparam int              LG    = $clog2(TN);
    localparam int              SH    = 32 + LG;
    localparam bit              SUB   = (j % 2) == 1;
    localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(TN) - 64'd1) / 64'(TN);

    logic [64:0] c_q;

    // Fold in the pending term and form t*g
    always_ff @(posedge clk) begin
      if (rst) begin
        b_v[j] <= 1'b0;
      end else if (adv) begin
        b_v[j] <= c_v[j-1];
      end
      if (adv) begin
        if (SUB) begin
          b_s[j] <= c_s[j-1] - ONE_W'(c_t[j-1]);
        end else begin
          b_s[j] <= c_s[j-1] + ONE_W'(c_t[j-1]);
        end
        b_m[j]    <= 64'(c_t[j-1]) * 64'(c_g[j-1]);
        b_g[j]    <= c_g[j-1];
        b_k[j]    <= c_k[j-1];
        b_side[j] <= c_side[j-1];
      end
    end

    // Divide by the term number through its reciprocal
    assign c_q = 65'(b_m[j][63:32]) * 65'(RECIP[32:0]);

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[j] <= 1'b0;
      end else if (adv) begin
        c_v[j] <= b_v[j];
      end
      if (adv) begin
        c_t[j]    <= 32'(c_q >> SH);
        c_s[j]    <= b_s[j];
        c_g[j]    <= b_g[j];
        c_k[j]    <= b_k[j];
        c_side[j] <= b_side[j];
      end
    end
  end

  // Unused head slot of the product stage
  assign b_m[0]    = '0;
  assign b_s[0]    = '0;
  assign b_g[0]    = '0;
  assign b_k[0]    = '0;
  assign b_side[0] = '0;
  assign b_v[0]    = 1'b0;

  // Fold in the last term, then scale by 2^-k
  localparam bit LAST_SUB = ((NUM_TERMS + 1) % 2) == 1;

  always_comb begin
    if (LAST_SUB) begin
      f_s = c_s[NUM_TERMS] - ONE_W'(c_t[NUM_TERMS]);
    end else begin
      f_s = c_s[NUM_TERMS] + ONE_W'(c_t[NUM_TERMS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_v[NUM_TERMS];
    end
    if (adv) begin
      if (c_k[NUM_TERMS] > K_W'(32)) begin
        out_val <= '0;
      end else begin
        out_val <= f_s >> c_k[NUM_TERMS];
      end
      out_side <= c_side[NUM_TERMS];
    end
  end

endmodule

@@ hw/rtl/disk_bulge_surface_brightness_core.sv @@
// ----------------------------------------------------------------------------
// disk_bulge_surface_brightness_core
// Galaxy surface brightness at a sky position: exponential disk plus
// optional bulge term, with cutoff and saturation.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while no result is held; the depth is set by
//   the four square-root pipelines (one root bit per stage, 107 stages) and the
//   38-term exponential series (two stages per term, 78 stages).
// A held result freezes the whole pipeline until it is taken.
// Reset (rst, synchronous) clears every valid bit and the configuration
//   registers; datapath registers keep their contents.
`include "assert_macros.svh"

module disk_bulge_surface_brightness_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dbsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbsb_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              pos_valid,
  output logic                              pos_ready,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [31:0]                       brightness
);

  import dbsb_pkg::*;

  // Configuration registers
  logic [39:0] shape_xx;
  logic [39:0] shape_yy;
  logic [39:0] shape_xy;
  logic [31:0] disk_norm;
  logic [31:0] bulge_norm;
  logic [39:0] bulge_inv_radius_sq;
  logic        bulge_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_xx            <= '0;
      shape_yy            <= '0;
      shape_xy            <= '0;
      disk_norm           <= '0;
      bulge_norm          <= '0;
      bulge_inv_radius_sq <= '0;
      bulge_enable        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHAPE_XX:      shape_xx            <= cfg_data;
        REG_SHAPE_YY:      shape_yy            <= cfg_data;
        REG_SHAPE_XY:      shape_xy            <= cfg_data;
        REG_DISK_NORM:     disk_norm           <= cfg_data[31:0];
        REG_BULGE_NORM:    bulge_norm          <= cfg_data[31:0];
        REG_BULGE_INV_RSQ: bulge_inv_radius_sq <= cfg_data;
        REG_BULGE_ENABLE:  bulge_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result is held at the output
  logic adv;
  assign adv       = !res_valid || res_ready;
  assign pos_ready = adv;

  // Stage 1: magnitudes and product sign
  logic [31:0] x_raw, y_raw;
  logic [31:0] xm, ym;
  logic        sgn1, v1;

  assign x_raw = pos_x;
  assign y_raw = pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pos_valid;
    end
    if (adv) begin
      xm   <= x_raw[31] ? (~x_raw + 32'd1) : x_raw;
      ym   <= y_raw[31] ? (~y_raw + 32'd1) : y_raw;
      sgn1 <= x_raw[31] ^ y_raw[31];
    end
  end

  // Stage 2: squares and cross product
  logic [62:0] x2, y2, xy;
  logic        sgn2, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      x2   <= 63'(xm) * 63'(xm);
      y2   <= 63'(ym) * 63'(ym);
      xy   <= 63'(xm) * 63'(ym);
      sgn2 <= sgn1;
    end
  end

  // Stage 3: partial products of the quadratic form, circular radius
  logic [39:0] cxy_mag;
  logic [71:0] pxl, pyl, pcl;
  logic [70:0] pxh, pyh, pch;
  logic [63:0] rr;
  logic        cneg3, v3;

  assign cxy_mag = shape_xy[39] ? (~shape_xy + 40'd1) : shape_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      pxl   <= 72'(shape_xx) * 72'(x2[31:0]);
      pxh   <= 71'(shape_xx) * 71'(x2[62:32]);
      pyl   <= 72'(shape_yy) * 72'(y2[31:0]);
      pyh   <= 71'(shape_yy) * 71'(y2[62:32]);
      pcl   <= 72'(cxy_mag) * 72'(xy[31:0]);
      pch   <= 71'(cxy_mag) * 71'(xy[62:32]);
      rr    <= 64'(x2) + 64'(y2);
      cneg3 <= sgn2 ^ shape_xy[39];
    end
  end

  // Stage 4: join the partial products, bulge partial products
  logic [102:0] px, py, pc;
  logic [71:0]  pbl, pbh;
  logic         cneg4, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      px    <= {pxh, 32'b0} + 103'(pxl);
      py    <= {pyh, 32'b0} + 103'(pyl);
      pc    <= {pch, 32'b0} + 103'(pcl);
      pbl   <= 72'(rr[31:0]) * 72'(bulge_inv_radius_sq);
      pbh   <= 72'(rr[63:32]) * 72'(bulge_inv_radius_sq);
      cneg4 <= cneg3;
    end
  end

  // Stage 5: signed quadratic form and scaled bulge radius
  logic [105:0] q5;
  logic [103:0] p5;
  logic         v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      q5 <= 106'(px) + 106'(py) + (cneg4 ? (~106'(pc) + 106'd1) : 106'(pc));
      p5 <= {pbh, 32'b0} + 104'(pbl);
    end
  end

  // Classify the far and negative cases ahead of the roots
  flags_t flags5;

  assign flags5.disk_neg  = q5[105];
  assign flags5.disk_far  = !q5[105] && (|q5[104:74]);
  assign flags5.bulge_far = |p5[103:80];

  // Disk radius r in Q16
  localparam int SQ1_SIDE_W = 64 + FLAGS_W;
  localparam int SQ2_SIDE_W = 21 + FLAGS_W;

  logic                  sq1_valid;
  logic [20:0]           sq1_root;
  logic [SQ1_SIDE_W-1:0] sq1_side;
  logic [63:0]           bulge_a;
  flags_t                flags_a;

  dbsb_isqrt #(.RAD_W(42), .SIDE_W(SQ1_SIDE_W)) u_sqrt_disk (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v5),
    .in_rad    (q5[73:32]),
    .in_side   ({p5[79:16], flags5}),
    .out_valid (sq1_valid),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  assign {bulge_a, flags_a} = sq1_side;

  // Bulge: three nested roots give u^(1/8) in Q24
  logic                  sq2_valid, sq3_valid, sq4_valid;
  logic [31:0]           sq2_root;
  logic [27:0]           sq3_root;
  logic [25:0]           sq4_root;
  logic [SQ2_SIDE_W-1:0] sq2_side, sq3_side, sq4_side;

  dbsb_isqrt #(.RAD_W(64), .SIDE_W(SQ2_SIDE_W)) u_sqrt_b1 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq1_valid),
    .in_rad    (bulge_a),
    .in_side   ({sq1_root, flags_a}),
    .out_valid (sq2_valid),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  dbsb_isqrt #(.RAD_W(56), .SIDE_W(SQ2_SIDE_W)) u_sqrt_b2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq2_valid),
    .in_rad    ({sq2_root, 24'b0}),
    .in_side   (sq2_side),
    .out_valid (sq3_valid),
    .out_root  (sq3_root),
    .out_side  (sq3_side)
  );

  dbsb_isqrt #(.RAD_W(52), .SIDE_W(SQ2_SIDE_W)) u_sqrt_b3 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq3_valid),
    .in_rad    ({sq3_root, 24'b0}),
    .in_side   (sq3_side),
    .out_valid (sq4_valid),
    .out_root  (sq4_root),
    .out_side  (sq4_side)
  );

  // Stage 7: base-2 exponents of both terms
  logic [20:0]         r16;
  flags_t              flags_r;
  logic [EXPO_W-1:0]   wd7, wb7;
  flags_t              flags7;
  logic                v7;

  assign {r16, flags_r} = sq4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= sq4_valid;
    end
    if (adv) begin
      wd7    <= EXPO_W'((54'(r16) * 54'(LOG2E_Q32)) >> 16);
      wb7    <= EXPO_W'((54'(sq4_root) * 54'(BULGE_K_Q24)) >> 16);
      flags7 <= flags_r;
    end
  end

  // Exponentials of the disk and bulge terms, run side by side
  logic             ed_valid, eb_valid;
  logic [ONE_W-1:0] e_d, e_b;
  logic [1:0]       ed_side;
  logic             eb_side;

  dbsb_exp2 #(.SIDE_W(2)) u_exp_disk (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v7),
    .in_expo   (wd7),
    .in_side   ({flags7.disk_neg, flags7.disk_far}),
    .out_valid (ed_valid),
    .out_val   (e_d),
    .out_side  (ed_side)
  );

  dbsb_exp2 #(.SIDE_W(1)) u_exp_bulge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v7),
    .in_expo   (wb7),
    .in_side   (flags7.bulge_far),
    .out_valid (eb_valid),
    .out_val   (e_b),
    .out_side  (eb_side)
  );

  // Stage 8: scale both terms by their norms
  logic [ONE_W-1:0] ed_sel;
  logic [31:0]      dterm, bterm;
  logic             v8;

  always_comb begin
    if (ed_side[1]) begin
      ed_sel = EXP_ONE;
    end else if (ed_side[0]) begin
      ed_sel = '0;
    end else begin
      ed_sel = e_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= ed_valid && eb_valid;
    end
    if (adv) begin
      dterm <= 32'((65'(disk_norm) * 65'(ed_sel)) >> 32);
      if (bulge_enable && !eb_side) begin
        bterm <= 32'((65'(bulge_norm) * 65'(e_b)) >> 32);
      end else begin
        bterm <= '0;
      end
    end
  end

  // Stage 9: sum and active norm total
  logic [32:0] sum9, active9, norm_total;
  logic        v9;

  assign norm_total = 33'(disk_norm) + (bulge_enable ? 33'(bulge_norm) : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
    if (adv) begin
      sum9    <= 33'(dterm) + 33'(bterm);
      active9 <= norm_total;
    end
  end

  // Stage 10: cutoff and saturation into the output register
  logic [46:0] scaled9;
  logic        below_cut;

  assign scaled9   = 47'(sum9) * 47'(CUTOFF_SCALE);
  assign below_cut = scaled9 < 47'(active9);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v9;
    end
    if (adv) begin
      if (below_cut) begin
        brightness <= '0;
      end else if (sum9[32]) begin
        brightness <= '1;
      end else begin
        brightness <= sum9[31:0];
      end
    end
  end

  // Checks
  `DBSB_ASSERT_ALWAYS(a_exp_lockstep, clk, rst, ed_valid == eb_valid, "exp units out of step")
  `DBSB_ASSERT_IMPLIES(a_exp_bound, clk, rst, ed_valid, e_d <= EXP_ONE, "disk exp above one")
  `DBSB_ASSERT_IMPLIES(a_res_bound, clk, rst, res_valid, 33'(brightness) <= norm_total, "result above norms")

endmodule

@@ tb/dbsb_checker.sv @@
// ----------------------------------------------------------------------------
// dbsb_checker
// Watches the configuration port and both channels of the brightness core,
// predicts each result from the accepted position and the current register
// values, and compares every result in order.
// ----------------------------------------------------------------------------
module dbsb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dbsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbsb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pos_valid,
  input  logic                           pos_ready,
  input  logic signed [31:0]             pos_x,
  input  logic signed [31:0]             pos_y,
  input  logic                           res_valid,
  input  logic                           res_ready,
  input  logic [31:0]                    brightness,
  output int                             fail_count,
  output int                             pending
);
  import dbsb_pkg::*;

  // Register shadows
  logic [39:0] m_xx, m_yy, m_xy, m_irsq;
  logic [31:0] m_dnorm, m_bnorm;
  logic        m_ben;

  logic [31:0] expected_brightness[$];

  assign pending = expected_brightness.size();

  // Integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^-w in Q32 from w in Q32
  function automatic logic [63:0] exp2_neg(input logic [63:0] w);
    logic [63:0]  k, f, g, s, t;
    logic [127:0] prod;
    k = w >> 32;
    f = w & 64'hFFFF_FFFF;
    prod = f * 128'(32'd2977044472);
    g = prod[95:32];
    s = 64'd1 << 32;
    t = 64'd1 << 32;
    if (k > 32) return 0;
    for (int n = 1; n < 40; n++) begin
      prod = t * g;
      t = prod[95:32] / n;
      if (t == 0) break;
      if (n % 2 == 1) s = s - t; else s = s + t;
    end
    return s >> k;
  endfunction

  function automatic logic [31:0] predict_brightness(input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
    logic signed [129:0] q, p;
    logic [63:0]  xm, ym, e, dterm, bterm, sum, active, s, r16, a, s1, s2, v;
    logic [127:0] prod;
    xm = x < 0 ? 64'(-64'(x)) : 64'(x);
    ym = y < 0 ? 64'(-64'(y)) : 64'(y);
    q = $signed({90'd0, m_xx}) * $signed({66'd0, xm * xm})
      + $signed({90'd0, m_yy}) * $signed({66'd0, ym * ym})
      + $signed({{90{m_xy[39]}}, m_xy}) * $signed(130'(64'(x) * 64'(y)) );
    q = $signed({90'd0, m_xx}) * $signed({66'd0, xm * xm})
      + $signed({90'd0, m_yy}) * $signed({66'd0, ym * ym})
      + $signed({{90{m_xy[39]}}, m_xy}) * ($signed({{66{x[31]}}, x}) * $signed({{98{y[31]}}, y}));
    if (q < 0) e = 64'd1 << 32;
    else if (q >= (130'sd1 <<< 74)) e = 0;
    else begin
      s   = 64'(q >>> 32);
      r16 = root_floor(s);
      prod = r16 * 128'(33'd6196328019);
      e = exp2_neg(prod[79:16]);
    end
    dterm = (64'(m_dnorm) * e) >> 32;
    bterm = 0;
    if (m_ben) begin
      p = $signed({66'd0, xm * xm + ym * ym}) * $signed({90'd0, m_irsq});
      if (p < (130'sd1 <<< 80)) begin
        a  = 64'(p >>> 16);
        s1 = root_floor(a);
        s2 = root_floor(s1 << 24);
        v  = root_floor(s2 << 24);
        prod = v * 128'(28'd185630853);
        e = exp2_neg(prod[79:16]);
        bterm = (64'(m_bnorm) * e) >> 32;
      end
    end
    sum    = dterm + bterm;
    active = 64'(m_dnorm) + (m_ben ? 64'(m_bnorm) : 64'd0);
    if (sum * 10000 < active) sum = 0;
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    return sum[31:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_xx <= 0; m_yy <= 0; m_xy <= 0; m_irsq <= 0;
      m_dnorm <= 0; m_bnorm <= 0; m_ben <= 0;
      fail_count <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SHAPE_XX:      m_xx    <= cfg_data;
          REG_SHAPE_YY:      m_yy    <= cfg_data;
          REG_SHAPE_XY:      m_xy    <= cfg_data;
          REG_DISK_NORM:     m_dnorm <= cfg_data[31:0];
          REG_BULGE_NORM:    m_bnorm <= cfg_data[31:0];
          REG_BULGE_INV_RSQ: m_irsq  <= cfg_data;
          REG_BULGE_ENABLE:  m_ben   <= cfg_data[0];
          default: ;
        endcase
      end
      // Predict on each accepted position
      if (pos_valid && pos_ready)
        expected_brightness.push_back(predict_brightness(pos_x, pos_y));
      // Compare each accepted result
      if (res_valid && res_ready) begin
        if (expected_brightness.size() == 0) begin
          $error("unexpected result brightness=%0d", brightness);
          fail_count <= fail_count + 1;
        end else begin
          logic [31:0] exp_b;
          exp_b = expected_brightness.pop_front();
          if (exp_b !== brightness) begin
            $error("brightness mismatch: expected %0d actual %0d", exp_b, brightness);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_disk_bulge_surface_brightness_core.sv @@
// ----------------------------------------------------------------------------
// tb_disk_bulge_surface_brightness_core
// Drives register settings and position streams with random bursts and
// back-pressure, including one long output hold-off; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_disk_bulge_surface_brightness_core;
  import dbsb_pkg::*;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 pos_valid = 0;
  logic                 pos_ready;
  logic signed [31:0]   pos_x = 0, pos_y = 0;
  logic                 res_valid;
  logic                 res_ready = 0;
  logic [31:0]          brightness;
  int                   fail_count, pending;
  int                   cycle_count = 0;
  bit                   hold_off_req = 0;

  always #6 clk = ~clk;

  disk_bulge_surface_brightness_core uut (.*);

  dbsb_checker chk (.*);

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern plus one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        res_ready <= 0;
        hold_off_req = 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      case (cycle_count % 500 < 150 ? 0 : 1)
        0: res_ready <= 1'b1;
        default: res_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Write one register; the caller drops the write enable afterwards
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Send one position; valid stays high through the handshake
  task automatic send_pos(input logic [31:0] x, input logic [31:0] y);
    pos_valid <= 1;
    pos_x <= x;
    pos_y <= y;
    do @(posedge clk); while (!pos_ready);
  endtask

  task automatic drain();
    pos_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int scale);
    logic [31:0] v;
    v = $urandom;
    case (scale)
      0: v = $signed(v) >>> $urandom_range(0, 31);
      1: v = $signed(v) >>> $urandom_range(8, 24);
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_phase(input int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_pos(rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pos_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_all(input logic [39:0] xx, input logic [39:0] yy,
                         input logic [39:0] xy, input logic [31:0] dn,
                         input logic [31:0] bn, input logic [39:0] ir,
                         input logic en);
    write_reg(REG_SHAPE_XX, xx);
    write_reg(REG_SHAPE_YY, yy);
    write_reg(REG_SHAPE_XY, xy);
    write_reg(REG_DISK_NORM, {8'd0, dn});
    write_reg(REG_BULGE_NORM, {8'd0, bn});
    write_reg(REG_BULGE_INV_RSQ, ir);
    write_reg(REG_BULGE_ENABLE, {39'd0, en});
    cfg_we <= 0;
  endtask

  initial begin
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: moderate shape, bulge on
    set_all(40'd65536, 40'd131072, -40'sd30000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            40'd65536, 1);
    foreach (edge_vals[i]) send_pos(edge_vals[i], edge_vals[(i + 2) % 6]);
    send_pos(32'h0, 32'h0);
    send_pos(32'h8000_0000, 32'h8000_0000);
    drain();

    // Negative quadratic form and extreme coefficients
    set_all(40'd1, 40'd1, 40'h80_0000_0000, 32'd1000, 32'd0, 40'hFF_FFFF_FFFF, 0);
    foreach (edge_vals[i]) send_pos(edge_vals[i], edge_vals[5 - i]);
    send_pos(32'h0100_0000, 32'h0100_0000);
    send_pos(32'h0100_0000, 32'hFF00_0000);
    drain();

    // Random phases over several settings, with a long hold-off in the first
    hold_off_req = 1;
    set_all(40'd65536, 40'd65536, 40'd0, $urandom, $urandom, 40'd65536, 1);
    random_phase(400);
    drain();
    set_all({$urandom, 8'd0} >> $urandom_range(0, 40), {$urandom, 8'd0} >> $urandom_range(0, 40),
            {$urandom, 8'd0} >> $urandom_range(0, 30), $urandom, $urandom,
            {$urandom, 8'd0} >> $urandom_range(0, 40), 1);
    random_phase(400);
    drain();
    set_all(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'h7F_FFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1);
    random_phase(300);
    drain();
    set_all(40'd0, 40'd0, 40'd0, 32'd0, 32'd0, 40'd0, 0);
    random_phase(200);
    drain();
    set_all({$urandom, 8'd0} >> $urandom_range(10, 40), {$urandom, 8'd0} >> $urandom_range(10, 40),
            {$urandom, 8'd0} >> $urandom_range(10, 40), $urandom, $urandom,
            {$urandom, 8'd0} >> $urandom_range(10, 40), 1'($urandom_range(0, 1)));
    random_phase(600);
    drain();

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dbsb_pkg.sv
hw/rtl/dbsb_isqrt.sv
hw/rtl/dbsb_exp2.sv
hw/rtl/disk_bulge_surface_brightness_core.sv
tb/dbsb_checker.sv
tb/tb_disk_bulge_surface_brightness_core.sv
